FILE: hdl/tnf_pkg.sv
// Shared types, constants and helper functions for the tanh neuron block.
package tnf_pkg;

  localparam int DATA_W = 16;
  localparam int ACT_W  = 14;
  localparam int MUL_W  = 18;
  localparam int PROD_W = 36;
  localparam int RES_W  = 24;

  localparam logic [15:0] LEARN_RATE_RST = 16'd655;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_FORWARD = 2'd1,
    OP_TRAIN   = 2'd2,
    OP_BIAS    = 2'd3
  } op_t;

  // rounding shift applied to the product
  typedef enum logic [1:0] {
    SH_10 = 2'd0,
    SH_12 = 2'd1,
    SH_16 = 2'd2
  } shift_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FWD_MUL,
    ST_FWD_ACC,
    ST_FWD_SUM,
    ST_FWD_TANH,
    ST_FWD_FIN,
    ST_TR_SQ,
    ST_TR_RATE,
    ST_TR_DERIV,
    ST_TR_GRAD,
    ST_TR_UPD,
    ST_EMIT
  } state_t;

  // tanh(k/4) in Q1.12, k = 0..32
  function automatic logic [12:0] tanh_lut(input logic [5:0] k);
    logic [12:0] v;
    case (k)
      6'd0:  v = 13'd0;
      6'd1:  v = 13'd1003;
      6'd2:  v = 13'd1893;
      6'd3:  v = 13'd2602;
      6'd4:  v = 13'd3119;
      6'd5:  v = 13'd3475;
      6'd6:  v = 13'd3707;
      6'd7:  v = 13'd3856;
      6'd8:  v = 13'd3949;
      6'd9:  v = 13'd4006;
      6'd10: v = 13'd4041;
      6'd11: v = 13'd4062;
      6'd12: v = 13'd4076;
      6'd13: v = 13'd4084;
      6'd14: v = 13'd4089;
      6'd15: v = 13'd4091;
      6'd16: v = 13'd4093;
      6'd17: v = 13'd4094;
      6'd18: v = 13'd4095;
      6'd19: v = 13'd4095;
      default: v = 13'd4096;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat_to16(input logic signed [32:0] v);
    logic signed [15:0] r;
    if (v > 33'sd32767) r = 16'sh7FFF;
    else if (v < -33'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic ovf16(input logic signed [32:0] v);
    return (v > 33'sd32767) || (v < -33'sd32768);
  endfunction

endpackage

FILE: hdl/tnf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tnf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/tnf_mulrnd.sv
// Shared signed multiplier with round-half-up right shift; the product is registered.
module tnf_mulrnd (
  input  logic                                clk,
  input  logic signed [tnf_pkg::MUL_W-1:0]    op_a,
  input  logic signed [tnf_pkg::MUL_W-1:0]    op_b,
  input  tnf_pkg::shift_t                     shift,
  output logic signed [tnf_pkg::RES_W-1:0]    res
);
  import tnf_pkg::*;

  logic signed [PROD_W-1:0] prod_r, prod_nxt, rnd;
  shift_t                   sh_r;

  // rounding constant is folded into the product so the output is a plain shift
  always_comb begin
    case (shift)
      SH_10:   rnd = 36'sd512;
      SH_12:   rnd = 36'sd2048;
      SH_16:   rnd = 36'sd32768;
      default: rnd = 36'sd0;
    endcase
    prod_nxt = op_a * op_b + rnd;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    sh_r   <= shift;
  end

  always_comb begin
    case (sh_r)
      SH_10:   res = RES_W'(prod_r >>> 10);
      SH_12:   res = RES_W'(prod_r >>> 12);
      SH_16:   res = RES_W'(prod_r >>> 16);
      default: res = '0;
    endcase
  end

endmodule

FILE: hdl/tanh_neuron_forward_and_train.sv
// Top level: single tanh neuron with stored weights, forward pass and training.
//
// Input channel in_*: in_tuser carries the op, in_tlast marks the last word of a
// forward or train pass, in_tdata carries source, weight and error values.
// Result channel out_*: one word per finished forward or train pass, carrying
// activation and sum (or updated bias), with the saturation flag on out_tuser.
// cfg_we/cfg_wdata write the Q0.16 learning rate; only write while idle.
//
// Steps, all work runs through one shared multiplier, one item at a time:
//   append weight, set bias : taken in the idle step, in_tready stays high
//   forward word            : multiply, accumulate; last: sum, tanh, finish, emit
//   train word              : four products, weight update; last: emit
// in_tready is high only while the sequencer is idle. A finished result sits in
// the output register; the block keeps accepting words while it waits, and
// holds in its emit step only if a second result arrives before the first is
// taken. Reset clears bias, counters, accumulator, stored activation and sets
// the learning rate to 655; weight storage is not cleared (only appended
// entries are ever used).
module tanh_neuron_forward_and_train #(
  parameter int MAX_INPUTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // source_value, weight_value, error_value
  input  logic [1:0]  in_tuser,   // op
  input  logic        in_tlast,   // last_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // activation_out, sum_out, zero pad
  output logic        out_tuser,  // saturated
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import tnf_pkg::*;

  localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int CW = $clog2(MAX_INPUTS + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt, pos_r, pos_nxt, pos_inc;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [DATA_W-1:0] bias_r, bias_nxt;
  logic signed [ACT_W-1:0] act_r, act_nxt;
  logic pass_sat_r, pass_sat_nxt;
  logic [15:0] rate_r, rate_nxt;
  logic signed [DATA_W-1:0] x_r, x_nxt, err_r, err_nxt;
  logic last_r, last_nxt;
  logic signed [13:0] d_r, d_nxt;
  logic signed [DATA_W-1:0] sum_r, sum_nxt;
  logic fsat_r, fsat_nxt;
  logic [12:0] base_r, base_nxt;
  logic neg_r, neg_nxt;
  logic signed [ACT_W-1:0] res_act_r, res_act_nxt;
  logic signed [DATA_W-1:0] res_sum_r, res_sum_nxt;
  logic res_sat_r, res_sat_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [ACT_W-1:0] out_act_r, out_act_nxt;
  logic signed [DATA_W-1:0] out_sum_r, out_sum_nxt;
  logic out_sat_r, out_sat_nxt;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic signed [DATA_W-1:0] ram_rdata;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  shift_t mul_sh;
  logic signed [RES_W-1:0] mul_res;
  logic signed [16:0] mul_t17;

  op_t in_op;
  logic accept, in_range;
  logic signed [32:0] sum_wide;
  logic signed [17:0] bias_wide;
  logic signed [24:0] w_wide;
  logic signed [16:0] mag;
  logic [14:0] mag_c;
  logic [12:0] lut_lo, lut_hi, lut_diff, y;
  logic signed [ACT_W-1:0] y14, act_fin;

  tnf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_INPUTS)
  ) u_weights (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (pos_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  tnf_mulrnd u_mul (
    .clk   (clk),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .shift (mul_sh),
    .res   (mul_res)
  );

  assign in_op     = op_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_range  = (pos_r < count_r);
  assign pos_inc   = (pos_r < CW'(MAX_INPUTS)) ? pos_r + CW'(1) : pos_r;
  assign mul_t17   = mul_res[16:0];

  assign sum_wide  = 33'(acc_r) + 33'(bias_r);
  assign bias_wide = 18'(bias_r) - 18'(mul_t17);
  assign w_wide    = 25'(ram_rdata) - 25'(mul_res);

  // tanh: clamp |s|, 5-bit segment index, 10-bit fraction
  assign mag      = sum_r[15] ? -(17'(sum_r)) : 17'(sum_r);
  assign mag_c    = (mag > 17'sd32767) ? 15'h7FFF : mag[14:0];
  assign lut_lo   = tanh_lut({1'b0, mag_c[14:10]});
  assign lut_hi   = tanh_lut({1'b0, mag_c[14:10]} + 6'd1);
  assign lut_diff = lut_hi - lut_lo;
  assign y        = base_r + mul_res[12:0];
  assign y14      = {1'b0, y};
  assign act_fin  = neg_r ? -y14 : y14;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    acc_nxt      = acc_r;
    bias_nxt     = bias_r;
    act_nxt      = act_r;
    pass_sat_nxt = pass_sat_r;
    rate_nxt     = cfg_we ? cfg_wdata : rate_r;
    x_nxt        = x_r;
    err_nxt      = err_r;
    last_nxt     = last_r;
    d_nxt        = d_r;
    sum_nxt      = sum_r;
    fsat_nxt     = fsat_r;
    base_nxt     = base_r;
    neg_nxt      = neg_r;
    res_act_nxt  = res_act_r;
    res_sum_nxt  = res_sum_r;
    res_sat_nxt  = res_sat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_act_nxt  = out_act_r;
    out_sum_nxt  = out_sum_r;
    out_sat_nxt  = out_sat_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = count_r[AW-1:0];
    ram_wdata    = in_tdata[31:16];
    mul_a        = 18'(x_r);
    mul_b        = '0;
    mul_sh       = SH_12;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          x_nxt    = in_tdata[15:0];
          err_nxt  = in_tdata[47:32];
          last_nxt = in_tlast;
          case (in_op)
            OP_APPEND: begin
              if (count_r < CW'(MAX_INPUTS)) begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_FORWARD: begin
              ram_re    = 1'b1;
              state_nxt = ST_FWD_MUL;
            end
            OP_TRAIN: begin
              ram_re    = 1'b1;
              state_nxt = ST_TR_SQ;
            end
            OP_BIAS: begin
              bias_nxt     = in_tdata[31:16];
              count_nxt    = '0;
              pos_nxt      = '0;
              acc_nxt      = '0;
              pass_sat_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_FWD_MUL: begin
        mul_a     = 18'(x_r);
        mul_b     = in_range ? 18'(ram_rdata) : '0;
        mul_sh    = SH_12;
        state_nxt = ST_FWD_ACC;
      end
      ST_FWD_ACC: begin
        acc_nxt = acc_r + 32'(mul_res);
        if (last_r) begin
          pos_nxt   = '0;
          state_nxt = ST_FWD_SUM;
        end else begin
          pos_nxt   = pos_inc;
          state_nxt = ST_IDLE;
        end
      end
      ST_FWD_SUM: begin
        sum_nxt   = sat_to16(sum_wide);
        fsat_nxt  = ovf16(sum_wide);
        acc_nxt   = '0;
        state_nxt = ST_FWD_TANH;
      end
      ST_FWD_TANH: begin
        mul_a     = {5'b0, lut_diff};
        mul_b     = {8'b0, mag_c[9:0]};
        mul_sh    = SH_10;
        base_nxt  = lut_lo;
        neg_nxt   = sum_r[15];
        state_nxt = ST_FWD_FIN;
      end
      ST_FWD_FIN: begin
        act_nxt     = act_fin;
        res_act_nxt = act_fin;
        res_sum_nxt = sum_r;
        res_sat_nxt = fsat_r;
        state_nxt   = ST_EMIT;
      end
      ST_TR_SQ: begin
        mul_a     = 18'(act_r);
        mul_b     = 18'(act_r);
        mul_sh    = SH_12;
        state_nxt = ST_TR_RATE;
      end
      ST_TR_RATE: begin
        d_nxt     = 14'sd4096 - 14'(mul_res);
        mul_a     = 18'(err_r);
        mul_b     = {2'b0, rate_r};
        mul_sh    = SH_16;
        state_nxt = ST_TR_DERIV;
      end
      ST_TR_DERIV: begin
        mul_a     = 18'(mul_t17);
        mul_b     = 18'(d_r);
        mul_sh    = SH_12;
        state_nxt = ST_TR_GRAD;
      end
      ST_TR_GRAD: begin
        // bias moves once per pass, on the word taken at position zero
        if (pos_r == '0) begin
          bias_nxt     = sat_to16(33'(bias_wide));
          pass_sat_nxt = pass_sat_r | ovf16(33'(bias_wide));
        end
        mul_a     = 18'(mul_t17);
        mul_b     = 18'(x_r);
        mul_sh    = SH_12;
        state_nxt = ST_TR_UPD;
      end
      ST_TR_UPD: begin
        if (in_range) begin
          ram_we       = 1'b1;
          ram_waddr    = pos_r[AW-1:0];
          ram_wdata    = sat_to16(33'(w_wide));
          pass_sat_nxt = pass_sat_r | ovf16(33'(w_wide));
        end
        if (last_r) begin
          res_act_nxt  = act_r;
          res_sum_nxt  = bias_r;
          res_sat_nxt  = pass_sat_nxt;
          pass_sat_nxt = 1'b0;
          pos_nxt      = '0;
          state_nxt    = ST_EMIT;
        end else begin
          pos_nxt   = pos_inc;
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_act_nxt   = res_act_r;
          out_sum_nxt   = res_sum_r;
          out_sat_nxt   = res_sat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pos_r       <= '0;
      acc_r       <= '0;
      bias_r      <= '0;
      act_r       <= '0;
      pass_sat_r  <= 1'b0;
      rate_r      <= LEARN_RATE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
      bias_r      <= bias_nxt;
      act_r       <= act_nxt;
      pass_sat_r  <= pass_sat_nxt;
      rate_r      <= rate_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    err_r     <= err_nxt;
    last_r    <= last_nxt;
    d_r       <= d_nxt;
    sum_r     <= sum_nxt;
    fsat_r    <= fsat_nxt;
    base_r    <= base_nxt;
    neg_r     <= neg_nxt;
    res_act_r <= res_act_nxt;
    res_sum_r <= res_sum_nxt;
    res_sat_r <= res_sat_nxt;
    out_act_r <= out_act_nxt;
    out_sum_r <= out_sum_nxt;
    out_sat_r <= out_sat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_sum_r, out_act_r};
  assign out_tuser  = out_sat_r;

  a_counters_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CW'(MAX_INPUTS)) && (pos_r <= CW'(MAX_INPUTS)))
    else $error("weight count or position beyond MAX_INPUTS");

  a_bias_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_op == OP_BIAS) |=>
      (count_r == '0) && (pos_r == '0) && (acc_r == '0) && !pass_sat_r)
    else $error("set-bias word did not clear pass state");

  a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_EMIT))
    else $error("result word loaded outside emit step");

  a_single_cycle_ops: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ((in_op == OP_APPEND) || (in_op == OP_BIAS)) |=> in_tready)
    else $error("append or set-bias word did not finish in one cycle");

endmodule
